[design/s2a_pkg.sv]
// shared types and constants for the signed integer to decimal text unit
package s2a_pkg;

  localparam int VALUE_W     = 32;
  localparam int CHAR_W      = 8;
  localparam int NUM_POS     = 10;
  localparam int POS_W       = $clog2(NUM_POS);
  localparam int THR_W       = 34;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'd57;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

  // decimal place weights, place 0 first
  localparam logic [THR_W-1:0] POW10 [NUM_POS] = '{
    34'd1, 34'd10, 34'd100, 34'd1000, 34'd10000, 34'd100000,
    34'd1000000, 34'd10000000, 34'd100000000, 34'd1000000000
  };

  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [1:0] {
    BACK_IDLE,
    BACK_SIGN,
    BACK_DIGIT
  } back_state_t;

endpackage

[design/s2a_front.sv]
// front end: splits the incoming integer into sign and unsigned magnitude
module s2a_front (
  input  logic signed [s2a_pkg::VALUE_W-1:0] value,
  output s2a_pkg::item_t                     item
);

  logic [s2a_pkg::VALUE_W-1:0] raw;

  assign raw      = s2a_pkg::VALUE_W'(value);
  assign item.neg = raw[s2a_pkg::VALUE_W-1];
  // most negative value wraps to its correct unsigned magnitude
  assign item.mag = item.neg ? (s2a_pkg::VALUE_W'(0) - raw) : raw;

endmodule

[design/s2a_queue.sv]
// short queue of classified items between front end and digit engine
module s2a_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  s2a_pkg::item_t         push_item,
  input  logic                   pop,
  output s2a_pkg::item_t         pop_item,
  output s2a_pkg::queue_status_t status
);

  s2a_pkg::item_t                    mem [s2a_pkg::QUEUE_DEPTH];
  logic [s2a_pkg::QPTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [s2a_pkg::QPTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [s2a_pkg::QCNT_W-1:0]        count_r, count_nxt;

  function automatic logic [s2a_pkg::QPTR_W-1:0] ptr_inc(input logic [s2a_pkg::QPTR_W-1:0] p);
    logic [s2a_pkg::QPTR_W-1:0] r;
    if (p == s2a_pkg::QPTR_W'(s2a_pkg::QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + s2a_pkg::QPTR_W'(1);
    end
    return r;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + s2a_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - s2a_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  assign pop_item     = mem[rd_ptr_r];
  assign status.full  = (count_r == s2a_pkg::QCNT_W'(s2a_pkg::QUEUE_DEPTH));
  assign status.empty = (count_r == '0);

endmodule

[design/s2a_back.sv]
// digit engine: one decimal place per cycle, most significant first
module s2a_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  s2a_pkg::queue_status_t       status,
  input  s2a_pkg::item_t               item,
  output logic                         pop,
  output logic                         strobe,
  output logic [s2a_pkg::CHAR_W-1:0]   text_char,
  output logic                         last_char
);

  s2a_pkg::back_state_t              state_r, state_nxt;
  logic [s2a_pkg::VALUE_W-1:0]       rem_r, rem_nxt;
  logic [s2a_pkg::POS_W-1:0]         pos_r, pos_nxt;
  logic                              seen_r, seen_nxt;
  logic                              strobe_r, strobe_nxt;
  logic [s2a_pkg::CHAR_W-1:0]        char_r, char_nxt;
  logic                              last_r, last_nxt;

  logic [s2a_pkg::THR_W-1:0]         weight;
  logic [s2a_pkg::THR_W-1:0]         rem_ext;
  logic [s2a_pkg::THR_W-1:0]         thr [1:9];
  logic [s2a_pkg::THR_W-1:0]         sub;
  logic [3:0]                        dig;

  // compare the remainder against all nine multiples of the place weight
  always_comb begin
    weight  = s2a_pkg::POW10[pos_r];
    rem_ext = s2a_pkg::THR_W'(rem_r);
    dig     = '0;
    sub     = '0;
    for (int d = 1; d <= 9; d++) begin
      thr[d] = weight * s2a_pkg::THR_W'(d);
      if (rem_ext >= thr[d]) begin
        dig = 4'(d);
        sub = thr[d];
      end
    end
  end

  always_comb begin
    state_nxt  = state_r;
    rem_nxt    = rem_r;
    pos_nxt    = pos_r;
    seen_nxt   = seen_r;
    pop        = 1'b0;
    strobe_nxt = 1'b0;
    char_nxt   = char_r;
    last_nxt   = 1'b0;
    case (state_r)
      s2a_pkg::BACK_IDLE: begin
        if (!status.empty) begin
          pop = 1'b1;
        end
      end
      s2a_pkg::BACK_SIGN: begin
        strobe_nxt = 1'b1;
        char_nxt   = s2a_pkg::ASCII_MINUS;
        state_nxt  = s2a_pkg::BACK_DIGIT;
      end
      s2a_pkg::BACK_DIGIT: begin
        // leading zeros are dropped, but the units place always shows
        strobe_nxt = (dig != '0) || seen_r || (pos_r == '0);
        char_nxt   = s2a_pkg::ASCII_ZERO + s2a_pkg::CHAR_W'(dig);
        last_nxt   = (pos_r == '0);
        rem_nxt    = s2a_pkg::VALUE_W'(rem_ext - sub);
        seen_nxt   = seen_r || (dig != '0);
        pos_nxt    = pos_r - s2a_pkg::POS_W'(1);
        if (pos_r == '0) begin
          if (!status.empty) begin
            pop = 1'b1;
          end else begin
            state_nxt = s2a_pkg::BACK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = s2a_pkg::BACK_IDLE;
      end
    endcase
    if (pop) begin
      rem_nxt   = item.mag;
      pos_nxt   = s2a_pkg::POS_W'(s2a_pkg::NUM_POS - 1);
      seen_nxt  = 1'b0;
      state_nxt = item.neg ? s2a_pkg::BACK_SIGN : s2a_pkg::BACK_DIGIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= s2a_pkg::BACK_IDLE;
      strobe_r <= 1'b0;
      seen_r   <= 1'b0;
      pos_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
      seen_r   <= seen_nxt;
      pos_r    <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign strobe    = strobe_r;
  assign text_char = char_r;
  assign last_char = strobe_r & last_r;

endmodule

[design/signed_int_to_decimal_ascii_unit.sv]
// top level: signed 32-bit integer to decimal ascii text, one character per strobe
//
// usage:
//   an integer is taken on in_value at a clock edge where start is high and
//   busy is low. its decimal text leaves on out_text_char, one character per
//   out_strobe cycle, most significant first: '-' for negative numbers, then
//   the digits without leading zeros ('0' alone for zero). out_last_char
//   marks the final character of each number. no terminator is sent.
// timing:
//   the digit engine steps through one decimal place per cycle (ten places),
//   after a minus sign for negative numbers, and an idle engine first has to
//   fetch the number from the queue. with the engine idle, the first
//   character of a positive number waits while the engine steps through its
//   leading zero places; a minus sign is sent before those places.
//   a two-entry queue sits between the input side and the digit engine, so
//   up to two numbers can be taken while one is being converted; busy is
//   high while that queue is full.
// reset: rst_n is synchronous and active low; it empties the queue and stops
//   any conversion in progress. the receiver cannot stall: each character
//   is valid for exactly the one cycle that out_strobe is high.
module signed_int_to_decimal_ascii_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [s2a_pkg::VALUE_W-1:0]  in_value,
  output logic                                out_strobe,
  output logic [s2a_pkg::CHAR_W-1:0]          out_text_char,
  output logic                                out_last_char
);

  s2a_pkg::item_t         front_item;
  s2a_pkg::item_t         queue_item;
  s2a_pkg::queue_status_t queue_status;
  logic                   push;
  logic                   pop;

  assign busy = queue_status.full;
  assign push = start & ~queue_status.full;

  s2a_front u_front (
    .value (in_value),
    .item  (front_item)
  );

  s2a_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .pop       (pop),
    .pop_item  (queue_item),
    .status    (queue_status)
  );

  s2a_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .status    (queue_status),
    .item      (queue_item),
    .pop       (pop),
    .strobe    (out_strobe),
    .text_char (out_text_char),
    .last_char (out_last_char)
  );

endmodule

[design/s2a_checker.sv]
// port-level checks for the decimal text unit, bound to the top level
module s2a_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               busy,
  input logic                               out_strobe,
  input logic [s2a_pkg::CHAR_W-1:0]         out_text_char,
  input logic                               out_last_char
);

  // nothing pending or flowing right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $rose(rst_n) |-> (!busy && !out_strobe))
    else $error("busy or strobe active right after reset");

  // the last flag only travels with a character
  a_last_with_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_char |-> out_strobe)
    else $error("last flag without a character");

  // only a minus sign or a decimal digit is ever sent
  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ((out_text_char == s2a_pkg::ASCII_MINUS) ||
                    ((out_text_char >= s2a_pkg::ASCII_ZERO) &&
                     (out_text_char <= s2a_pkg::ASCII_NINE))))
    else $error("character outside the decimal text set");

  // a minus sign never closes a number
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_text_char == s2a_pkg::ASCII_MINUS)) |-> !out_last_char)
    else $error("minus sign flagged as last character");

  // a minus sign is never followed directly by another minus sign
  a_no_double_minus: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_text_char == s2a_pkg::ASCII_MINUS)) |=>
      !(out_strobe && (out_text_char == s2a_pkg::ASCII_MINUS)))
    else $error("two minus signs in a row");

endmodule

bind signed_int_to_decimal_ascii_unit s2a_checker u_s2a_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .busy          (busy),
  .out_strobe    (out_strobe),
  .out_text_char (out_text_char),
  .out_last_char (out_last_char)
);

[dv/signed_int_to_decimal_ascii_unit_tb.sv]
// testbench for the signed integer to decimal ascii unit: random and corner values, text scoreboard
module signed_int_to_decimal_ascii_unit_tb;

  localparam int RANDOM_ITEMS   = 198;
  localparam int STALL_LIMIT    = 2000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int REPORT_MAX     = 10;

  typedef struct packed {
    logic [s2a_pkg::CHAR_W-1:0] ch;
    logic                       is_last;
  } text_char_t;

  typedef struct packed {
    logic [s2a_pkg::VALUE_W-1:0] value;
    logic                        drain_first;
  } number_req_t;

  logic                                clk;
  logic                                rst_n;
  logic                                start;
  logic                                busy;
  logic signed [s2a_pkg::VALUE_W-1:0]  in_value;
  logic                                out_strobe;
  logic [s2a_pkg::CHAR_W-1:0]          out_text_char;
  logic                                out_last_char;

  number_req_t numbers_pending[$];
  text_char_t  text_expected[$];

  logic took_number;
  int   numbers_total;
  int   numbers_taken;
  int   chars_checked;
  int   negatives_taken;
  int   full_width_taken;
  int   mismatches;
  int   quiet_cycles;

  signed_int_to_decimal_ascii_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_value      (in_value),
    .out_strobe    (out_strobe),
    .out_text_char (out_text_char),
    .out_last_char (out_last_char)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // expected text of one number, most significant character first
  function automatic void predict_decimal_text(input logic [s2a_pkg::VALUE_W-1:0] word);
    logic                        neg;
    logic [s2a_pkg::VALUE_W-1:0] mag;
    logic [s2a_pkg::VALUE_W-1:0] rem;
    logic [s2a_pkg::CHAR_W-1:0]  digits [s2a_pkg::NUM_POS];
    int                          n;
    text_char_t                  e;
    neg = word[s2a_pkg::VALUE_W-1];
    mag = neg ? (32'd0 - word) : word;
    rem = mag % 10;
    digits[0] = s2a_pkg::ASCII_ZERO + rem[s2a_pkg::CHAR_W-1:0];
    mag = mag / 10;
    n = 1;
    while (mag != 0) begin
      rem = mag % 10;
      digits[n] = s2a_pkg::ASCII_ZERO + rem[s2a_pkg::CHAR_W-1:0];
      mag = mag / 10;
      n++;
    end
    if (neg) begin
      e.ch = s2a_pkg::ASCII_MINUS;
      e.is_last = 1'b0;
      text_expected.push_back(e);
      negatives_taken++;
    end
    if (n + (neg ? 1 : 0) == s2a_pkg::NUM_POS + 1) full_width_taken++;
    for (int k = n - 1; k >= 0; k--) begin
      e.ch = digits[k];
      e.is_last = (k == 0);
      text_expected.push_back(e);
    end
  endfunction

  function automatic void queue_number(input logic [s2a_pkg::VALUE_W-1:0] v, input logic drain);
    number_req_t r;
    r.value = v;
    r.drain_first = drain;
    numbers_pending.push_back(r);
    numbers_total++;
  endfunction

  // random value with a chosen digit count, so short numbers are common
  function automatic logic [s2a_pkg::VALUE_W-1:0] random_number();
    int                          ndig;
    logic [s2a_pkg::VALUE_W-1:0] lo;
    logic [s2a_pkg::VALUE_W-1:0] hi;
    logic [s2a_pkg::VALUE_W-1:0] v;
    if ($urandom_range(99) < 20) begin
      v = $urandom;
    end else begin
      ndig = $urandom_range(s2a_pkg::NUM_POS, 1);
      lo = (ndig == 1) ? 32'd0 : s2a_pkg::POW10[ndig-1][s2a_pkg::VALUE_W-1:0];
      hi = (ndig == s2a_pkg::NUM_POS) ? 32'h7fff_ffff
                                      : s2a_pkg::POW10[ndig][s2a_pkg::VALUE_W-1:0] - 1;
      v = $urandom_range(hi, lo);
      if ($urandom_range(1)) v = 32'd0 - v;
    end
    return v;
  endfunction

  // driver: new transaction offered on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || took_number) begin
      if (numbers_pending.size() != 0
          && !(numbers_pending[0].drain_first && text_expected.size() != 0)
          && !((numbers_taken < 70 || numbers_taken >= 140) && $urandom_range(99) < 9)) begin
        start <= 1'b1;
        in_value <= numbers_pending[0].value;
        numbers_pending.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor, scoreboard and stall watchdog
  always @(posedge clk) begin
    took_number <= rst_n && start && !busy;
    if (rst_n) begin
      if ((start && !busy) || out_strobe) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (start && !busy) begin
        predict_decimal_text(in_value);
        numbers_taken++;
      end
      if (out_strobe) begin
        chars_checked++;
        if (text_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected character: char=%0d last=%0b", out_text_char, out_last_char);
        end else begin
          if (text_expected[0].ch !== out_text_char
              || text_expected[0].is_last !== out_last_char) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("character mismatch: expected char=%0d last=%0b, got char=%0d last=%0b",
                       text_expected[0].ch, text_expected[0].is_last,
                       out_text_char, out_last_char);
          end
          text_expected.pop_front();
        end
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("signed_int_to_decimal_ascii_unit_tb failed");
        $finish;
      end
    end
  end

  initial begin
    logic [s2a_pkg::VALUE_W-1:0] corner_values [22];
    rst_n = 1'b0;
    start = 1'b0;
    in_value = '0;
    took_number = 1'b0;
    numbers_total = 0;
    numbers_taken = 0;
    chars_checked = 0;
    negatives_taken = 0;
    full_width_taken = 0;
    mismatches = 0;
    quiet_cycles = 0;

    corner_values = '{
      32'd0, 32'd1, 32'hffff_ffff, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
      32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001, 32'd1000000000, 32'd999999999,
      -32'sd999999999, 32'd1000000009, 32'd123456789, -32'sd1000000000, -32'sd9,
      32'd5, -32'sd1234567, 32'haaaa_aaaa, 32'h5555_5555
    };
    foreach (corner_values[i]) queue_number(corner_values[i], 1'b0);
    // sender holds off until the unit has drained before random traffic starts
    queue_number(random_number(), 1'b1);
    for (int i = 1; i < RANDOM_ITEMS; i++)
      queue_number(random_number(), ($urandom_range(99) < 3));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (numbers_taken < numbers_total) @(negedge clk);
    while (text_expected.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("converted %0d numbers (%0d negative, %0d of eleven characters), %0d characters",
             numbers_taken, negatives_taken, full_width_taken, chars_checked);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("signed_int_to_decimal_ascii_unit_tb passed");
    end else begin
      $display("signed_int_to_decimal_ascii_unit_tb failed");
    end
    $finish;
  end

endmodule
